// ===== rtl/tga_pkg.sv =====
package tga_pkg;

    localparam int SUM_W = 40;
    localparam int CNT_W = 32;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_TRUE  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_RAW,
        PH_PKTHDR,
        PH_PKTDAT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DIV,
        C_OUT
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;
        logic       start_div;
        logic       load_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       emit;
        logic       div_needed;
        logic       div_done;
    } dp_stat_t;

endpackage

// ===== rtl/tga_divider.sv =====
module tga_divider
    import tga_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] num_r,
    input  logic [SUM_W-1:0] num_g,
    input  logic [SUM_W-1:0] num_b,
    input  logic [CNT_W-1:0] den,
    output logic             done,
    output logic [7:0]       q_r,
    output logic [7:0]       q_g,
    output logic [7:0]       q_b
);
    // restoring division, one quotient bit per cycle per channel
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] nr_reg, ng_reg, nb_reg;
    logic [SUM_W-1:0] qr_reg, qg_reg, qb_reg;
    logic [CNT_W:0]   rr_reg, rg_reg, rb_reg;
    logic [CNT_W-1:0] den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CNT_W:0] tr, tg, tb;
    logic [CNT_W:0] dx;

    assign dx = {1'b0, den_reg};
    assign tr = {rr_reg[CNT_W-1:0], nr_reg[SUM_W-1]};
    assign tg = {rg_reg[CNT_W-1:0], ng_reg[SUM_W-1]};
    assign tb = {rb_reg[CNT_W-1:0], nb_reg[SUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(SUM_W);
                nr_reg <= num_r; ng_reg <= num_g; nb_reg <= num_b;
                rr_reg <= '0; rg_reg <= '0; rb_reg <= '0;
                den_reg <= den;
            end else if (busy_reg) begin
                nr_reg <= nr_reg << 1;
                ng_reg <= ng_reg << 1;
                nb_reg <= nb_reg << 1;
                rr_reg <= (tr >= dx) ? tr - dx : tr;
                rg_reg <= (tg >= dx) ? tg - dx : tg;
                rb_reg <= (tb >= dx) ? tb - dx : tb;
                qr_reg <= {qr_reg[SUM_W-2:0], tr >= dx};
                qg_reg <= {qg_reg[SUM_W-2:0], tg >= dx};
                qb_reg <= {qb_reg[SUM_W-2:0], tb >= dx};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q_r  = qr_reg[7:0];
    assign q_g  = qg_reg[7:0];
    assign q_b  = qb_reg[7:0];
endmodule

// ===== rtl/tga_datapath.sv =====
module tga_datapath
    import tga_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        colour_enable,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [2:0]  status,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [7:0]  avg_red,
    output logic [7:0]  avg_green,
    output logic [7:0]  avg_blue
);
    phase_t           phase_reg, phase_next;
    logic [4:0]       hidx_reg, hidx_next;
    logic [7:0]       idl_reg, idl_next;
    logic             map_reg, map_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       depth_reg, depth_next;
    logic [15:0]      w_reg, w_next, h_reg, h_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [6:0]       raw_reg, raw_next;
    logic [7:0]       rep_reg, rep_next;
    logic             run_reg, run_next;
    logic [1:0]       slot_reg, slot_next;
    logic [15:0]      part_reg, part_next;
    logic [SUM_W-1:0] sr_reg, sr_next, sg_reg, sg_next, sb_reg, sb_next;

    // pixel add is registered: a pixel's colour and count, then one multiply each
    logic             pend_reg;
    logic [7:0]       pr_reg, pg_reg, pb_reg;
    logic [7:0]       pcnt_reg;
    logic             padd;
    logic [7:0]       pcnt;

    logic             emit_c, avg_c;
    logic [2:0]       st_c;
    logic [2:0]       st_reg;
    logic             avg_reg;
    logic [CNT_W-1:0] npix_reg;

    logic [7:0]       sub;
    logic [CNT_W-1:0] wh;
    logic [8:0]       runcnt;
    logic [CNT_W-1:0] cnt_c;
    logic [7:0]       qr, qg, qb;
    logic             ddone;

    logic [15:0] w0, h0;
    logic [CNT_W-1:0] left0;
    phase_t ph0;
    logic [4:0] hidx0;

    assign wh = CNT_W'(w_next) * CNT_W'(h_next);

    always_comb begin
        ph0 = first_byte ? PH_HEADER : phase_reg;
        hidx0 = first_byte ? 5'd0 : hidx_reg;
        w0 = first_byte ? 16'd0 : w_reg;
        h0 = first_byte ? 16'd0 : h_reg;
        left0 = first_byte ? '0 : left_reg;
        phase_next = ph0;
        hidx_next = hidx0;
        idl_next = first_byte ? 8'd0 : idl_reg;
        map_next = first_byte ? 1'b0 : map_reg;
        kind_next = first_byte ? 8'd0 : kind_reg;
        depth_next = first_byte ? 8'd0 : depth_reg;
        w_next = w0;
        h_next = h0;
        left_next = left0;
        raw_next = first_byte ? 7'd0 : raw_reg;
        rep_next = first_byte ? 8'd0 : rep_reg;
        run_next = first_byte ? 1'b0 : run_reg;
        slot_next = first_byte ? 2'd0 : slot_reg;
        part_next = first_byte ? 16'd0 : part_reg;
        emit_c = 1'b0;
        avg_c = 1'b0;
        st_c = ST_OK;
        padd = 1'b0;
        pcnt = 8'd1;
        sub = 8'd0;
        runcnt = 9'd0;
        cnt_c = '0;
        case (ph0)
            PH_HEADER: begin
                case (hidx0)
                    5'd0:  idl_next = data_byte;
                    5'd1:  map_next = data_byte != 8'd0;
                    5'd2:  kind_next = data_byte;
                    5'd12: w_next = {w0[15:8], data_byte};
                    5'd13: w_next = {data_byte, w0[7:0]};
                    5'd14: h_next = {h0[15:8], data_byte};
                    5'd15: h_next = {data_byte, h0[7:0]};
                    5'd16: depth_next = data_byte;
                    default: ;
                endcase
                sub = (kind_next > 8'd8) ? kind_next - 8'd8 : kind_next;
                if (hidx0 == 5'd15 && !colour_enable) begin
                    emit_c = 1'b1;
                end else if (hidx0 >= 5'd17) begin
                    if (map_next || depth_next != 8'd24 || sub == 8'd1) begin
                        emit_c = 1'b1; st_c = ST_NOT_TRUE;
                    end else if (sub != 8'd2) begin
                        emit_c = 1'b1; st_c = ST_BAD_TYPE;
                    end else begin
                        left_next = wh;
                        if (idl_next != 8'd0) phase_next = PH_IDSKIP;
                        else if (wh == '0) begin
                            emit_c = 1'b1; st_c = ST_EMPTY;
                        end else begin
                            phase_next = (kind_next > 8'd8) ? PH_PKTHDR : PH_RAW;
                            slot_next = 2'd0;
                        end
                    end
                end else begin
                    hidx_next = hidx0 + 5'd1;
                end
            end
            PH_IDSKIP: begin
                idl_next = idl_reg - 8'd1;
                if (idl_next == 8'd0) begin
                    if (left0 == '0) begin
                        emit_c = 1'b1; st_c = ST_EMPTY;
                    end else begin
                        phase_next = (kind_reg > 8'd8) ? PH_PKTHDR : PH_RAW;
                        slot_next = 2'd0;
                    end
                end
            end
            PH_RAW, PH_PKTDAT: begin
                if (slot_reg == 2'd0) begin
                    part_next = {part_reg[15:8], data_byte}; slot_next = 2'd1;
                end else if (slot_reg == 2'd1) begin
                    part_next = {data_byte, part_reg[7:0]}; slot_next = 2'd2;
                end else begin
                    slot_next = 2'd0;
                    padd = 1'b1;
                    cnt_c = CNT_W'(1);
                    if (ph0 == PH_PKTDAT) begin
                        if (run_reg) begin
                            runcnt = {1'b0, rep_reg} + 9'd1;
                            cnt_c = (CNT_W'(runcnt) > left0) ? left0 : CNT_W'(runcnt);
                            rep_next = 8'd0;
                            phase_next = PH_PKTHDR;
                        end else if (raw_reg == 7'd0) begin
                            phase_next = PH_PKTHDR;
                        end else begin
                            raw_next = raw_reg - 7'd1;
                        end
                    end
                    pcnt = cnt_c[7:0];
                    left_next = left0 - cnt_c;
                    if (left_next == '0) begin
                        emit_c = 1'b1; avg_c = 1'b1;
                    end
                end
            end
            PH_PKTHDR: begin
                run_next = data_byte[7];
                rep_next = data_byte[7] ? {1'b0, data_byte[6:0]} : 8'd0;
                raw_next = data_byte[7] ? 7'd0 : data_byte[6:0];
                slot_next = 2'd0;
                phase_next = PH_PKTDAT;
            end
            default: ;
        endcase
        if (emit_c) phase_next = PH_DONE;
        else if (last_byte && phase_next != PH_DONE) begin
            emit_c = 1'b1; st_c = ST_TRUNC; phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hidx_reg <= '0; idl_reg <= '0; map_reg <= 1'b0; kind_reg <= '0;
            depth_reg <= '0; w_reg <= '0; h_reg <= '0; left_reg <= '0;
            raw_reg <= '0; rep_reg <= '0; run_reg <= 1'b0; slot_reg <= '0;
            part_reg <= '0; pend_reg <= 1'b0;
            sr_reg <= '0; sg_reg <= '0; sb_reg <= '0;
        end else begin
            pend_reg <= 1'b0;
            if (cmd.take_byte && first_byte) begin
                sr_reg <= '0; sg_reg <= '0; sb_reg <= '0;
            end else if (pend_reg) begin
                sr_reg <= sr_next; sg_reg <= sg_next; sb_reg <= sb_next;
            end
            if (cmd.take_byte) begin
                phase_reg <= phase_next; hidx_reg <= hidx_next; idl_reg <= idl_next;
                map_reg <= map_next; kind_reg <= kind_next; depth_reg <= depth_next;
                w_reg <= w_next; h_reg <= h_next; left_reg <= left_next;
                raw_reg <= raw_next; rep_reg <= rep_next; run_reg <= run_next;
                slot_reg <= slot_next; part_reg <= part_next;
                pend_reg <= padd;
                pr_reg <= data_byte; pg_reg <= part_next[15:8]; pb_reg <= part_next[7:0];
                pcnt_reg <= pcnt;
                st_reg <= st_c;
                avg_reg <= avg_c;
                npix_reg <= CNT_W'(w_next) * CNT_W'(h_next);
            end
        end
    end

    // sums wrap at 40 bits; a first byte drops the previous file's pending add
    always_comb begin
        sr_next = sr_reg + SUM_W'(16'(pr_reg) * 16'(pcnt_reg));
        sg_next = sg_reg + SUM_W'(16'(pg_reg) * 16'(pcnt_reg));
        sb_next = sb_reg + SUM_W'(16'(pb_reg) * 16'(pcnt_reg));
    end

    tga_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start_div),
        .num_r(sr_reg), .num_g(sg_reg), .num_b(sb_reg), .den(npix_reg),
        .done(ddone), .q_r(qr), .q_g(qg), .q_b(qb)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status <= st_reg;
            image_width <= w_reg;
            image_height <= h_reg;
            avg_red <= avg_reg ? qr : 8'd0;
            avg_green <= avg_reg ? qg : 8'd0;
            avg_blue <= avg_reg ? qb : 8'd0;
        end
    end

    assign stat.emit = emit_c;
    assign stat.div_needed = avg_c;
    assign stat.div_done = ddone;
endmodule

// ===== rtl/tga_ctrl.sv =====
module tga_ctrl
    import tga_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    ctl_state_t state_reg, state_next;
    logic       acc;
    logic       arm_reg;    // first cycle in C_DIV: the last pixel add lands here
    logic       wait_reg;   // start_div waits for arm_reg so the last pixel add lands before dividing
    logic       mv_reg, mv_next;

    assign acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            C_IDLE: if (acc && stat.emit) state_next = stat.div_needed ? C_DIV : C_OUT;
            C_DIV:  if (stat.div_done) state_next = C_OUT;
            C_OUT:  if (!mv_reg || m_ready) begin
                state_next = C_IDLE; mv_next = 1'b1;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        cmd.take_byte = acc;
        cmd.start_div = (state_reg == C_DIV) && wait_reg;
        cmd.load_out = (state_reg == C_OUT) && (!mv_reg || m_ready);
        s_ready = (state_reg == C_IDLE);
        m_valid = mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            mv_reg <= 1'b0;
            arm_reg <= 1'b0;
            wait_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            arm_reg <= (state_next == C_DIV) && (state_reg == C_IDLE);
            wait_reg <= arm_reg;
        end
    end
endmodule

// ===== rtl/tga_rle_average_colour_core.sv =====
// TGA average-colour core.
// Input channel (s_*): one file byte a beat, with first/last markers; a
// first-marked byte restarts header parsing for a new file.
// Result channel (m_*): at most one beat per file carrying status, size and
// the mean red, green and blue.
// Throughput: one byte a cycle while pixels stream. A final result stops
// input until it is in the output register (size only or error), and
// longer when the averages are computed: the last pixel add lands, then
// the restoring divider starts (one quotient bit a cycle over the 40-bit
// sums, three channels side by side), runs to done, and the output
// register loads. m_valid rises as the output register is loaded.
// colour_enable is sampled at header byte 15; write it only while idle.
// Reset (aresetn low, synchronous) returns to header parsing, colour on.
// A stalled receiver holds the result in the output register; input keeps
// flowing until a second result is ready, which then waits for the first.
module tga_rle_average_colour_core
    import tga_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_image_width,
    output logic [15:0] m_image_height,
    output logic [7:0]  m_avg_red,
    output logic [7:0]  m_avg_green,
    output logic [7:0]  m_avg_blue
);
    logic     colour_en_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) colour_en_reg <= 1'b1;
        else if (cfg_we) colour_en_reg <= cfg_wdata;
    end

    tga_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    tga_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .colour_enable(colour_en_reg),
        .data_byte(s_data_byte), .first_byte(s_first_byte), .last_byte(s_last_byte),
        .cmd(cmd), .stat(stat), .status(m_status), .image_width(m_image_width),
        .image_height(m_image_height), .avg_red(m_avg_red), .avg_green(m_avg_green),
        .avg_blue(m_avg_blue)
    );
endmodule

// ===== rtl/tga_checker.sv =====
module tga_checker
    import tga_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_avg_red,
    input logic [7:0]  m_avg_green,
    input logic [7:0]  m_avg_blue
);
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_EMPTY) else $error("status out of range");
    a_err_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
        (m_avg_red == 8'd0 && m_avg_green == 8'd0 && m_avg_blue == 8'd0))
        else $error("averages set on error");
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result dropped");
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> s_valid)
        else $error("input beat withdrawn");
endmodule

bind tga_rle_average_colour_core tga_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_avg_red(m_avg_red), .m_avg_green(m_avg_green), .m_avg_blue(m_avg_blue)
);

// ===== dv/tb_tga_rle_average_colour_core.sv =====
`timescale 1ns / 1ps

// Checks the TGA average-colour core against an in-bench model of the decoder.
// Byte stream of generated TGA files (raw, RLE, bad headers, cut files, noise)
// goes in over s_*; every m_* beat is compared with the oldest predicted
// result. The colour switch is changed only with the core drained.
module tb_tga_rle_average_colour_core;
    import tga_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 80;   // divide plus output registers
    localparam int ITEM_BUDGET     = 1250;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } tga_result_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } file_beat_t;

    // directed rows: typed result only where it can be read straight off
    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        typed;
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_first_byte = 1'b0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_image_width;
    logic [15:0] m_image_height;
    logic [7:0]  m_avg_red;
    logic [7:0]  m_avg_green;
    logic [7:0]  m_avg_blue;

    always #10 aclk = ~aclk;

    tga_rle_average_colour_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first_byte   (s_first_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height),
        .m_avg_red      (m_avg_red),
        .m_avg_green    (m_avg_green),
        .m_avg_blue     (m_avg_blue)
    );

    // ------------------------------------------------------------------
    // Decoder model: own copy of parse state and the colour switch
    // ------------------------------------------------------------------
    logic        mdl_colour_en;
    phase_t      mdl_phase;
    logic [4:0]  mdl_hdr_idx;
    logic [7:0]  mdl_id_len;
    logic        mdl_map;
    logic [7:0]  mdl_kind;
    logic [7:0]  mdl_depth;
    logic [15:0] mdl_width;
    logic [15:0] mdl_height;
    logic [31:0] mdl_pix_left;
    logic [6:0]  mdl_raw_left;
    logic [7:0]  mdl_rep_left;
    logic        mdl_in_run;
    logic [1:0]  mdl_slot;
    logic [15:0] mdl_partial;
    logic [39:0] mdl_sum_r, mdl_sum_g, mdl_sum_b;
    logic [7:0]  mdl_px_r, mdl_px_g, mdl_px_b;
    tga_result_t mdl_res;
    logic        mdl_got;

    function automatic void mdl_clear();
        mdl_phase = PH_HEADER;  mdl_hdr_idx = '0; mdl_id_len = '0; mdl_map = 1'b0;
        mdl_kind = '0; mdl_depth = '0; mdl_width = '0; mdl_height = '0;
        mdl_partial = '0; mdl_pix_left = '0; mdl_raw_left = '0; mdl_rep_left = '0;
        mdl_in_run = 1'b0; mdl_slot = '0;
        mdl_sum_r = '0; mdl_sum_g = '0; mdl_sum_b = '0;
    endfunction

    function automatic void mdl_emit(input logic [2:0] st, input logic with_avg);
        logic [63:0] npix;
        npix = 64'(mdl_width) * 64'(mdl_height);
        mdl_res.status = st;
        mdl_res.width  = mdl_width;
        mdl_res.height = mdl_height;
        mdl_res.red    = (with_avg && npix != 0) ? 8'(64'(mdl_sum_r) / npix) : 8'd0;
        mdl_res.green  = (with_avg && npix != 0) ? 8'(64'(mdl_sum_g) / npix) : 8'd0;
        mdl_res.blue   = (with_avg && npix != 0) ? 8'(64'(mdl_sum_b) / npix) : 8'd0;
        mdl_phase = PH_DONE;
        mdl_got = 1'b1;
    endfunction

    function automatic void mdl_start_pixels();
        if (mdl_pix_left == 0) begin
            mdl_emit(ST_EMPTY, 1'b0);
        end else begin
            mdl_phase = (mdl_kind > 8) ? PH_PKTHDR : PH_RAW;
            mdl_slot = '0;
        end
    endfunction

    // gathers B, G, R; true once the red byte lands
    function automatic logic mdl_take(input logic [7:0] b);
        if (mdl_slot == 0) begin
            mdl_partial[7:0] = b; mdl_slot = 2'd1; return 1'b0;
        end
        if (mdl_slot == 1) begin
            mdl_partial[15:8] = b; mdl_slot = 2'd2; return 1'b0;
        end
        mdl_slot = '0;
        mdl_px_b = mdl_partial[7:0];
        mdl_px_g = mdl_partial[15:8];
        mdl_px_r = b;
        return 1'b1;
    endfunction

    function automatic void mdl_add(input logic [31:0] cnt);
        mdl_sum_r = mdl_sum_r + 40'(mdl_px_r) * 40'(cnt);
        mdl_sum_g = mdl_sum_g + 40'(mdl_px_g) * 40'(cnt);
        mdl_sum_b = mdl_sum_b + 40'(mdl_px_b) * 40'(cnt);
        mdl_pix_left = mdl_pix_left - cnt;
    endfunction

    function automatic logic decode_byte(input logic [7:0] b, input logic is_first,
                                         input logic is_last);
        logic [7:0]  sub;
        logic [31:0] cnt;
        mdl_got = 1'b0;
        if (is_first) mdl_clear();
        case (mdl_phase)
            PH_HEADER: begin
                case (mdl_hdr_idx)
                    5'd0:  mdl_id_len = b;
                    5'd1:  mdl_map = (b != 0);
                    5'd2:  mdl_kind = b;
                    5'd12: mdl_width[7:0] = b;
                    5'd13: mdl_width[15:8] = b;
                    5'd14: mdl_height[7:0] = b;
                    5'd15: mdl_height[15:8] = b;
                    5'd16: mdl_depth = b;
                    default: ;
                endcase
                if (mdl_hdr_idx == 15 && !mdl_colour_en) begin
                    mdl_emit(ST_OK, 1'b0);
                end else if (mdl_hdr_idx >= 17) begin
                    sub = (mdl_kind > 8) ? mdl_kind - 8'd8 : mdl_kind;
                    if (mdl_map || mdl_depth != 24 || sub == 1) begin
                        mdl_emit(ST_NOT_TRUE, 1'b0);
                    end else if (sub != 2) begin
                        mdl_emit(ST_BAD_TYPE, 1'b0);
                    end else begin
                        mdl_pix_left = 32'(mdl_width) * 32'(mdl_height);
                        if (mdl_id_len != 0) mdl_phase = PH_IDSKIP;
                        else mdl_start_pixels();
                    end
                end else begin
                    mdl_hdr_idx = mdl_hdr_idx + 5'd1;
                end
            end
            PH_IDSKIP: begin
                mdl_id_len = mdl_id_len - 8'd1;
                if (mdl_id_len == 0) mdl_start_pixels();
            end
            PH_RAW: begin
                if (mdl_take(b)) begin
                    mdl_add(32'd1);
                    if (mdl_pix_left == 0) mdl_emit(ST_OK, 1'b1);
                end
            end
            PH_PKTHDR: begin
                mdl_in_run = b[7];
                mdl_rep_left = b[7] ? {1'b0, b[6:0]} : 8'd0;
                mdl_raw_left = b[7] ? 7'd0 : b[6:0];
                mdl_slot = '0;
                mdl_phase = PH_PKTDAT;
            end
            PH_PKTDAT: begin
                if (mdl_take(b)) begin
                    if (mdl_in_run) begin
                        cnt = 32'(mdl_rep_left) + 32'd1;
                        if (cnt > mdl_pix_left) cnt = mdl_pix_left;
                        mdl_add(cnt);
                        mdl_rep_left = '0;
                        mdl_phase = PH_PKTHDR;
                    end else begin
                        mdl_add(32'd1);
                        if (mdl_raw_left == 0) mdl_phase = PH_PKTHDR;
                        else mdl_raw_left = mdl_raw_left - 7'd1;
                    end
                    if (mdl_pix_left == 0) mdl_emit(ST_OK, 1'b1);
                end
            end
            default: ;
        endcase
        if (!mdl_got && is_last && mdl_phase != PH_DONE) mdl_emit(ST_TRUNC, 1'b0);
        return mdl_got;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    tga_result_t pending_results[$];
    file_beat_t  byte_queue[$];
    dir_row_t    dir_rows[$];
    dir_row_t    typed_rows[$];    // rows in flight that carry a typed result
    int          n_errors = 0;
    int          n_beats_in = 0;
    int          n_results = 0;
    int          n_files = 0;
    int          idle_cycles = 0;
    logic        stim_done = 1'b0;
    logic        long_hold_req = 1'b0;
    logic        quiet = 1'b0;   // no-gap stretch

    function automatic void report_mismatch(input string what, input tga_result_t exp_r,
                                            input tga_result_t act_r);
        n_errors++;
        if (n_errors <= 10)
            $display({"%0t %s: exp st=%0d w=%0d h=%0d rgb=%0d/%0d/%0d",
                      " act st=%0d w=%0d h=%0d rgb=%0d/%0d/%0d"},
                     $realtime, what, exp_r.status, exp_r.width, exp_r.height,
                     exp_r.red, exp_r.green, exp_r.blue, act_r.status, act_r.width,
                     act_r.height, act_r.red, act_r.green, act_r.blue);
    endfunction

    always @(posedge aclk) begin
        tga_result_t act_r, exp_r;
        logic got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                act_r = '{m_status, m_image_width, m_image_height,
                          m_avg_red, m_avg_green, m_avg_blue};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", act_r, act_r);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (act_r.status !== exp_r.status || act_r.width !== exp_r.width ||
                        act_r.height !== exp_r.height || act_r.red !== exp_r.red ||
                        act_r.green !== exp_r.green || act_r.blue !== exp_r.blue)
                        report_mismatch("result mismatch", exp_r, act_r);
                end
            end
            if (s_valid && s_ready) begin
                n_beats_in++;
                got = decode_byte(s_data_byte, s_first_byte, s_last_byte);
                if (got) pending_results.push_back(mdl_res);
            end
            // watchdog: runs until the stimulus is done and nothing is still owed
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (stim_done && pending_results.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("tb_tga_rle_average_colour_core: errors");
                $finish;
            end
        end
    end

    // typed directed expectations are checked against the model as it runs
    always @(posedge aclk) begin
        dir_row_t row;
        if (aresetn && s_valid && s_ready && typed_rows.size() != 0) begin
            #1;
            row = typed_rows.pop_front();
            if (row.typed && (!mdl_got || mdl_res.status !== row.status ||
                mdl_res.width !== row.width || mdl_res.height !== row.height ||
                mdl_res.red !== 8'd0 || mdl_res.green !== 8'd0 ||
                mdl_res.blue !== 8'd0))
                report_mismatch("directed row", '{row.status, row.width,
                                row.height, 8'd0, 8'd0, 8'd0}, mdl_res);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random hold-off per beat, one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_beat(input file_beat_t bt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data_byte  = bt.data;
        s_first_byte = bt.first;
        s_last_byte  = bt.last;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic flush_bytes();
        while (byte_queue.size() != 0) send_beat(byte_queue.pop_front());
        s_valid = 1'b0;
    endtask

    task automatic wait_drained(input int extra);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_colour_enable(input logic val);
        wait_drained(DRAIN_CYCLES);
        cfg_wdata = val;
        cfg_we    = 1'b1;
        @(negedge aclk);
        mdl_colour_en = val;
        cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic f);
        file_beat_t bt;
        bt.data = d; bt.first = f; bt.last = 1'b0;
        byte_queue.push_back(bt);
    endfunction

    function automatic void push_pixel();
        push_byte(pick_channel(), 1'b0);
        push_byte(pick_channel(), 1'b0);
        push_byte(pick_channel(), 1'b0);
    endfunction

    // one generated file, mostly well formed
    function automatic void build_file();
        logic [7:0]  id_len, kind, depth, pkt;
        logic [15:0] w, h;
        logic        cmap;
        int          remain, cnt, cut, i, sel;
        id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
        if ($urandom_range(0, 40) == 0) id_len = 8'hff;
        cmap = ($urandom_range(0, 15) == 0);
        sel = $urandom_range(0, 19);
        kind = (sel < 9) ? 8'd10 : (sel < 16) ? 8'd2 :
               (sel == 16) ? 8'd1 : (sel == 17) ? 8'd9 : 8'($urandom);
        depth = ($urandom_range(0, 12) == 0) ? 8'($urandom) : 8'd24;
        w = 16'($urandom_range(0, 5));
        h = 16'($urandom_range(0, 4));
        if ($urandom_range(0, 12) == 0) begin
            w = 16'($urandom_range(20, 60));
            h = 16'd1;
        end
        if ($urandom_range(0, 15) == 0) begin
            w = 16'($urandom);
            h = 16'($urandom);
        end
        push_byte(id_len, 1'b1);
        push_byte({7'd0, cmap} | (cmap ? 8'($urandom) : 8'd0), 1'b0);
        push_byte(kind, 1'b0);
        for (i = 3; i < 12; i++) push_byte(8'($urandom), 1'b0);
        push_byte(w[7:0], 1'b0);
        push_byte(w[15:8], 1'b0);
        push_byte(h[7:0], 1'b0);
        push_byte(h[15:8], 1'b0);
        push_byte(depth, 1'b0);
        push_byte(8'($urandom), 1'b0);
        for (i = 0; i < id_len; i++) push_byte(8'($urandom), 1'b0);
        remain = int'(w) * int'(h);
        if (remain > 400) remain = 400;   // large sizes are cut anyway
        if (kind == 8'd10) begin
            while (remain > 0) begin
                cnt = $urandom_range(0, (remain + 1 > 127) ? 127 : remain + 1);
                if ($urandom_range(0, 1)) begin
                    pkt = 8'h80 | 8'(cnt);
                    push_byte(pkt, 1'b0);
                    push_pixel();
                end else begin
                    pkt = 8'(cnt) & 8'h7f;
                    push_byte(pkt, 1'b0);
                    for (i = 0; i <= cnt; i++) push_pixel();
                end
                remain -= cnt + 1;
            end
        end else begin
            for (i = 0; i < remain; i++) push_pixel();
        end
        for (i = $urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : 0; i > 0; i--)
            push_byte(8'($urandom), 1'b0);
        if ($urandom_range(0, 6) == 0 && byte_queue.size() > 1) begin
            cut = $urandom_range(1, byte_queue.size() - 1);
            while (byte_queue.size() > cut) void'(byte_queue.pop_back());
        end
        if ($urandom_range(0, 7) != 0) byte_queue[byte_queue.size() - 1].last = 1'b1;
    endfunction

    function automatic void build_noise();
        file_beat_t bt;
        int i, len;
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++) begin
            bt.data  = 8'($urandom);
            bt.first = (i == 0) || ($urandom_range(0, 5) == 0);
            bt.last  = ($urandom_range(0, 6) == 0);
            byte_queue.push_back(bt);
        end
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic f, input logic l,
                                    input logic typed, input logic [2:0] st,
                                    input logic [15:0] w, input logic [15:0] h);
        dir_rows.push_back('{d, f, l, typed, st, w, h});
    endfunction

    initial begin
        int i, ph;
        logic hold_done;
        dir_row_t row;
        file_beat_t bt;
        hold_done = 1'b0;
        mdl_colour_en = 1'b1;
        mdl_clear();
        mdl_res = '{default: '0};
        mdl_got = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: lone byte that is both first and last -> cut file, no size
        add_row(8'h00, 1'b1, 1'b1, 1'b1, ST_TRUNC, 16'd0, 16'd0);
        // header of an unsupported type at the largest size, last on byte 17
        add_row(8'h00, 1'b1, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'h03, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        for (i = 3; i < 12; i++) add_row(8'hff, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        for (i = 12; i < 16; i++) add_row(8'hff, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'd24, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, ST_BAD_TYPE, 16'hffff, 16'hffff);
        // colour-mapped header cut short: first restarts, then a stray last
        add_row(8'h00, 1'b1, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'h01, 1'b0, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0);
        add_row(8'h02, 1'b0, 1'b1, 1'b1, ST_TRUNC, 16'd0, 16'd0);
        // byte after a result is ignored
        add_row(8'h5a, 1'b0, 1'b1, 1'b0, ST_OK, 16'd0, 16'd0);
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            typed_rows.push_back(row);
            bt.data = row.data; bt.first = row.first; bt.last = row.last;
            send_beat(bt);
        end
        s_valid = 1'b0;

        // random phases: colour on, off, on, off, then random, switching while drained
        for (ph = 0; ph < 5; ph++) begin
            write_colour_enable(ph == 4 ? 1'($urandom) : ~ph[0]);
            while (n_beats_in < (ph + 1) * ITEM_BUDGET / 5) begin
                n_files++;
                // back-to-back files while the receiver is held off fill the core
                quiet = long_hold_req || ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0) build_noise();
                else build_file();
                if (ph == 2 && !hold_done) begin
                    long_hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                flush_bytes();
                if (n_files % 15 == 0) wait_drained(0);
            end
        end
        quiet = 1'b0;
        stim_done = 1'b1;
        wait_drained(DRAIN_CYCLES);
        if (pending_results.size() != 0) n_errors++;
        $display("%0d file bytes in %0d files, %0d result beats, both colour settings",
                 n_beats_in, n_files, n_results);
        if (n_errors == 0)
            $display("tb_tga_rle_average_colour_core: clean");
        else
            $display("tb_tga_rle_average_colour_core: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tga_pkg.sv
rtl/tga_divider.sv
rtl/tga_datapath.sv
rtl/tga_ctrl.sv
rtl/tga_rle_average_colour_core.sv
rtl/tga_checker.sv
dv/tb_tga_rle_average_colour_core.sv
